[sv/lbr_pkg.sv]
// Package with the types, constants and sequencer states of the bounded random source.
package lbr_pkg;

  localparam int unsigned STEPS = 9;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [31:0] SEED_RESET = 32'h0000_30be;
  localparam logic [31:0] ZERO_RELOAD = 32'h0000_30be;

  typedef struct packed {
    logic [15:0] modulus;
    logic        start_at_one;
  } req_t;

  typedef struct packed {
    logic [9:0] value;
    logic       zero_modulus;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } lfsr_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } rem_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

[sv/lbr_lfsr.sv]
// Generator state register: 32-bit Fibonacci LFSR advanced one step per cycle while ctrl.step is set.
module lbr_lfsr (
  input  logic              clk,
  input  logic              rst,
  input  lbr_pkg::lfsr_ctrl_t ctrl,
  input  logic [31:0]       seed,
  output logic              fb
);
  import lbr_pkg::*;

  logic [31:0] gen_state;
  logic [31:0] gen_state_next;
  logic [31:0] shifted;

  assign fb = gen_state[0] ^ gen_state[1] ^ gen_state[2] ^ gen_state[4] ^
              gen_state[6] ^ gen_state[31];
  assign shifted = {fb, gen_state[31:1]};

  always_comb begin
    gen_state_next = gen_state;
    if (ctrl.load) begin
      gen_state_next = seed;
    end else if (ctrl.step) begin
      if (ctrl.last && (shifted == 32'd0)) begin
        gen_state_next = ZERO_RELOAD;
      end else begin
        gen_state_next = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= SEED_RESET;
    end else begin
      gen_state <= gen_state_next;
    end
  end

endmodule

[sv/lbr_rem.sv]
// Shift-and-subtract remainder unit taking one dividend bit per cycle while stepping, MSB first.
module lbr_rem (
  input  logic               clk,
  input  lbr_pkg::rem_ctrl_t ctrl,
  input  logic               bit_in,
  input  logic [15:0]        modulus,
  output logic [8:0]         rem
);
  import lbr_pkg::*;

  logic [9:0]  partial;
  logic [15:0] partial_ext;
  logic [15:0] diff;
  logic [8:0]  rem_next;

  assign partial     = {rem, bit_in};
  assign partial_ext = {6'd0, partial};
  assign diff        = partial_ext - modulus;

  always_comb begin
    rem_next = rem;
    if (ctrl.clear) begin
      rem_next = 9'd0;
    end else if (ctrl.step) begin
      if (partial_ext >= modulus) begin
        rem_next = diff[8:0];
      end else begin
        rem_next = partial[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
  end

endmodule

[sv/lfsr_bounded_random_core.sv]
// Top level of the bounded random source: sequencer, output register and configuration.
//
// A request transaction on req (valid/stall) carries a modulus n and a start_at_one flag.
// The block answers each request with exactly one response transaction on rsp:
// (r mod n) plus start_at_one, where r is nine fresh bits of the generator.
// A zero modulus returns value 0 with zero_modulus set.
// During a run the generator advances one step per cycle, and the remainder unit
// consumes each new bit in the same cycle, so r mod n is ready when the run ends.
// The response is then registered in the DONE state once the output register is free,
// and the sequencer returns to idle, where a new request is taken; a request is not
// taken before the last one is through. req_stall is high while a request is in work.
// A finished response waits in the output register while rsp_stall is high; the block
// may accept the next request meanwhile but holds its result until the register frees.
// The cfg channel (valid/ready) writes the start seed, which is loaded into the
// generator at once; cfg_ready is high only when no request is in work.
// Synchronous reset clears the sequencer and the response valid, and loads the
// generator with the default seed 0x30be.
module lfsr_bounded_random_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lbr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lbr_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import lbr_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  req_t             held;
  logic             fb;
  logic [8:0]       rem;
  lfsr_ctrl_t       lfsr_ctrl;
  rem_ctrl_t        rem_ctrl;
  logic             req_take;
  logic             rsp_load;
  logic             last_step;

  assign last_step = (cnt == CNT_W'(STEPS - 1));
  assign req_take  = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall      = 1'b1;
    cfg_ready      = 1'b0;
    rsp_load       = 1'b0;
    lfsr_ctrl.load = 1'b0;
    lfsr_ctrl.step = 1'b0;
    lfsr_ctrl.last = last_step;
    rem_ctrl.clear = 1'b0;
    rem_ctrl.step  = 1'b0;
    cnt_next       = cnt;
    case (state)
      ST_IDLE: begin
        req_stall      = 1'b0;
        cfg_ready      = 1'b1;
        lfsr_ctrl.load = cfg_valid;
        rem_ctrl.clear = 1'b1;
        cnt_next       = '0;
      end
      ST_RUN: begin
        lfsr_ctrl.step = 1'b1;
        rem_ctrl.step  = 1'b1;
        cnt_next       = cnt + CNT_W'(1);
      end
      ST_DONE: begin
        rsp_load = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      held <= req;
    end
    if (rsp_load) begin
      if (held.modulus == 16'd0) begin
        rsp.value        <= 10'd0;
        rsp.zero_modulus <= 1'b1;
      end else begin
        rsp.value        <= {1'b0, rem} + {9'd0, held.start_at_one};
        rsp.zero_modulus <= 1'b0;
      end
    end
  end

  lbr_lfsr u_lfsr (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lfsr_ctrl),
    .seed (cfg_data),
    .fb   (fb)
  );

  lbr_rem u_rem (
    .clk     (clk),
    .ctrl    (rem_ctrl),
    .bit_in  (fb),
    .modulus (held.modulus),
    .rem     (rem)
  );

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.zero_modulus |-> rsp.value == 10'd0)
    else $error("zero modulus response carries a non-zero value");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && held.modulus != 16'd0 |-> {7'd0, rem} < held.modulus)
    else $error("remainder not below modulus at end of run");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == ST_RUN && cnt == '0)
    else $error("accepted request did not start a run");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt < CNT_W'(STEPS))
    else $error("step counter overran");

endmodule
